>>> rtl/svwt_pkg.sv
// Shared types and action codes for the segment versus wall table hit test.
package svwt_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_QUERY = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

endpackage

>>> rtl/segment_vs_wall_table_hit_test.sv
// Top level of the segment versus wall table hit test with its sequencer.
//
// The block holds up to MAX_WALLS wall segments. A load or clear goes from
// its transfer straight to the result, and a query reads and tests walls one
// after another: the scan stops at the first wall that is hit, so the number
// of walls tested is at most the number of stored walls. Each wall costs one
// table read and three cross products issued back to back through a single
// two-stage multiply unit. A query on an empty table, and an unknown action,
// are answered at once with hit and table_full low. No new transfer is taken
// until the result has been taken. A parallel or collinear wall never counts
// as a hit.
module segment_vs_wall_table_hit_test
	import svwt_pkg::*;
#(
	parameter int MAX_WALLS   = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          table_full
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW + 1;
	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int NW = $clog2(MAX_WALLS + 1);
	localparam int WW = 4 * CW;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ   = 8'b0000_0010,
		ST_ISS_D  = 8'b0000_0100,
		ST_ISS_S  = 8'b0000_1000,
		ST_ISS_T  = 8'b0001_0000,
		ST_WAIT_S = 8'b0010_0000,
		ST_EVAL   = 8'b0100_0000,
		ST_RESP   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [NW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic hit_q;
	logic full_q;

	logic signed [DW-1:0] p0x_q, p0y_q, qx_q, qy_q;
	logic signed [DW-1:0] rx_q, ry_q, ox_q, oy_q;
	logic signed [PW-1:0] d_q, s_q;

	logic accept;
	logic room;
	logic wr_en;
	logic [WW-1:0] rd_data;
	logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;
	logic signed [DW-1:0] rx_c, ry_c, ox_c, oy_c;
	logic signed [DW-1:0] ua_x, ua_y, ub_x, ub_y;
	logic signed [PW-1:0] xprod;
	logic d_zero, pos, wall_hit, last_wall;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESP);
	assign hit = hit_q;
	assign table_full = full_q;
	assign room = (count_q < NW'(MAX_WALLS));
	assign wr_en = accept && (action_t'(action) == ACT_LOAD) && room;

	svwt_wall_mem #(
		.DEPTH(MAX_WALLS),
		.WIDTH(WW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data({start_x, start_y, end_x, end_y}),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	assign w_ax = rd_data[4*CW-1:3*CW];
	assign w_ay = rd_data[3*CW-1:2*CW];
	assign w_bx = rd_data[2*CW-1:CW];
	assign w_by = rd_data[CW-1:0];

	assign rx_c = DW'(w_bx) - DW'(w_ax);
	assign ry_c = DW'(w_by) - DW'(w_ay);
	assign ox_c = p0x_q - DW'(w_ax);
	assign oy_c = p0y_q - DW'(w_ay);

	always_comb begin
		ua_x = qx_q;
		ua_y = qy_q;
		ub_x = rx_c;
		ub_y = ry_c;
		case (state_q)
			ST_ISS_S: begin
				ub_x = ox_q;
				ub_y = oy_q;
			end
			ST_ISS_T: begin
				ua_x = rx_q;
				ua_y = ry_q;
				ub_x = ox_q;
				ub_y = oy_q;
			end
			default: begin
			end
		endcase
	end

	svwt_cross_unit #(
		.DW(DW)
	) u_cross (
		.clk  (clk),
		.a_x  (ua_x),
		.a_y  (ua_y),
		.b_x  (ub_x),
		.b_y  (ub_y),
		.xprod(xprod)
	);

	// In the evaluation cycle the unit output holds the third cross product.
	assign d_zero = (d_q == '0);
	assign pos = !d_zero && !d_q[PW-1];
	assign wall_hit = !d_zero && (s_q[PW-1] != pos) && (xprod[PW-1] != pos)
		&& ((s_q > d_q) != pos) && ((xprod > d_q) != pos);
	assign last_wall = ((NW'(idx_q) + NW'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			p0x_q <= DW'(start_x);
			p0y_q <= DW'(start_y);
			qx_q  <= DW'(end_x) - DW'(start_x);
			qy_q  <= DW'(end_y) - DW'(start_y);
		end
		if (state_q == ST_ISS_D) begin
			rx_q <= rx_c;
			ry_q <= ry_c;
			ox_q <= ox_c;
			oy_q <= oy_c;
		end
		if (state_q == ST_ISS_T) begin
			d_q <= xprod;
		end
		if (state_q == ST_WAIT_S) begin
			s_q <= xprod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q  <= 1'b0;
						full_q <= 1'b0;
						idx_q  <= '0;
						state_q <= ST_RESP;
						case (action_t'(action))
							ACT_LOAD: begin
								if (room) begin
									count_q <= count_q + NW'(1);
								end else begin
									full_q <= 1'b1;
								end
							end
							ACT_QUERY: begin
								if (count_q != '0) begin
									state_q <= ST_READ;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ:   state_q <= ST_ISS_D;
				ST_ISS_D:  state_q <= ST_ISS_S;
				ST_ISS_S:  state_q <= ST_ISS_T;
				ST_ISS_T:  state_q <= ST_WAIT_S;
				ST_WAIT_S: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (wall_hit || last_wall) begin
						hit_q   <= wall_hit;
						state_q <= ST_RESP;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_READ;
					end
				end
				ST_RESP: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_WALLS))
		else $error("Wall count exceeds the table depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !hit)
		else $error("A rejected load reports a hit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + NW'(1))
		else $error("A stored wall did not advance the wall count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> NW'(idx_q) < count_q)
		else $error("The scan reached a wall beyond the stored count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("The block did not return to idle after a result transfer.");

endmodule

>>> rtl/svwt_wall_mem.sv
// Wall table storage with one write port and one registered read port.
module svwt_wall_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/svwt_cross_unit.sv
// Two-stage shared cross-product unit computing a_x*b_y - a_y*b_x.
module svwt_cross_unit #(
	parameter int DW = 17,
	localparam int PW = 2 * DW + 1
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] a_x,
	input  logic signed [DW-1:0] a_y,
	input  logic signed [DW-1:0] b_x,
	input  logic signed [DW-1:0] b_y,
	output logic signed [PW-1:0] xprod
);

	logic signed [2*DW-1:0] prod_a_s1;
	logic signed [2*DW-1:0] prod_b_s1;
	logic signed [PW-1:0]   xprod_s2;

	always_ff @(posedge clk) begin
		prod_a_s1 <= a_x * b_y;
		prod_b_s1 <= a_y * b_x;
		xprod_s2  <= PW'(prod_a_s1) - PW'(prod_b_s1);
	end

	assign xprod = xprod_s2;

endmodule

>>> tb/segment_vs_wall_table_hit_test_test.sv
// Self-checking testbench for the segment versus wall table hit test block.
module segment_vs_wall_table_hit_test_test;
	import svwt_pkg::*;

	localparam int MAX_WALLS   = 64;
	localparam int COORD_WIDTH = 16;
	localparam int RANDOM_ITEMS = 1750;
	localparam action_t ACT_UNKNOWN = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		action_t act;
		coord_t  sx;
		coord_t  sy;
		coord_t  ex;
		coord_t  ey;
		bit      drain_first;
	} segment_item_t;

	typedef struct {
		bit hit;
		bit full;
	} answer_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	action_t action;
	coord_t  start_x;
	coord_t  start_y;
	coord_t  end_x;
	coord_t  end_y;
	logic    out_valid;
	logic    out_ready;
	logic    hit;
	logic    table_full;

	segment_item_t pending_items[$];
	answer_t       expected_answers[$];
	segment_item_t offered_item;
	bit            handed_over;
	int            items_sent;
	int            answers_seen;
	int            hold_left;
	bit            held_once;
	int            failures;

	coord_t model_ax[MAX_WALLS];
	coord_t model_ay[MAX_WALLS];
	coord_t model_bx[MAX_WALLS];
	coord_t model_by[MAX_WALLS];
	int     model_wall_count;

	segment_vs_wall_table_hit_test #(
		.MAX_WALLS(MAX_WALLS),
		.COORD_WIDTH(COORD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.table_full(table_full)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit segment_crosses_wall(segment_item_t q, int w);
		longint qx, qy, rx, ry, ox, oy, d, s, t;
		bit pos;
		qx = longint'(q.ex) - longint'(q.sx);
		qy = longint'(q.ey) - longint'(q.sy);
		rx = longint'(model_bx[w]) - longint'(model_ax[w]);
		ry = longint'(model_by[w]) - longint'(model_ay[w]);
		ox = longint'(q.sx) - longint'(model_ax[w]);
		oy = longint'(q.sy) - longint'(model_ay[w]);
		d = qx * ry - rx * qy;
		if (d == 0)
			return 1'b0;
		pos = d > 0;
		s = qx * oy - qy * ox;
		t = rx * oy - ry * ox;
		if (((s < 0) == pos) || ((t < 0) == pos))
			return 1'b0;
		if (((s > d) == pos) || ((t > d) == pos))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic answer_t apply_to_wall_table(segment_item_t it);
		answer_t a;
		a.hit = 1'b0;
		a.full = 1'b0;
		case (it.act)
			ACT_LOAD: begin
				if (model_wall_count >= MAX_WALLS) begin
					a.full = 1'b1;
				end else begin
					model_ax[model_wall_count] = it.sx;
					model_ay[model_wall_count] = it.sy;
					model_bx[model_wall_count] = it.ex;
					model_by[model_wall_count] = it.ey;
					model_wall_count++;
				end
			end
			ACT_QUERY: begin
				for (int w = 0; w < model_wall_count; w++) begin
					if (segment_crosses_wall(it, w)) begin
						a.hit = 1'b1;
						break;
					end
				end
			end
			ACT_CLEAR: begin
				model_wall_count = 0;
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic queue_item(action_t act, int sx, int sy, int ex, int ey,
			bit drain = 1'b0);
		segment_item_t it;
		it.act = act;
		it.sx = coord_t'(sx);
		it.sy = coord_t'(sy);
		it.ex = coord_t'(ex);
		it.ey = coord_t'(ey);
		it.drain_first = drain;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic int near_coord();
		return int'($urandom_range(0, 400)) - 200;
	endfunction

	function automatic int any_coord();
		return int'(coord_t'($urandom_range(0, 65535)));
	endfunction

	// Stimulus: directed corner cases, then clear/load/query sequences with occasional unknown actions.
	initial begin
		int wall_x0[$], wall_y0[$], wall_x1[$], wall_y1[$];
		int n_random, seq, n_walls, n_queries, pick, kind, w;
		int mx, my, px, py, dx, dy;
		bit wide;

		queue_item(ACT_CLEAR, 0, 0, 0, 0);
		queue_item(ACT_QUERY, -32768, -32768, 32767, 32767);
		queue_item(ACT_UNKNOWN, -1, -1, -1, -1);
		queue_item(ACT_LOAD, -32768, -32768, 32767, 32767);
		queue_item(ACT_QUERY, -32768, 32767, 32767, -32768);
		queue_item(ACT_QUERY, -32767, -32768, 32767, 32766);
		queue_item(ACT_QUERY, -100, -100, 100, 100);
		queue_item(ACT_QUERY, 0, 0, 100, -100);
		queue_item(ACT_QUERY, -100, 100, 0, 0);
		queue_item(ACT_CLEAR, 0, 0, 0, 0);
		queue_item(ACT_LOAD, 0, 0, 10, 0);
		queue_item(ACT_QUERY, 0, -5, 0, 5);
		queue_item(ACT_QUERY, 10, -5, 10, 5);
		queue_item(ACT_QUERY, 5, 0, 5, 7);
		queue_item(ACT_QUERY, 5, -7, 5, 0);
		queue_item(ACT_QUERY, 11, -5, 11, 5);
		queue_item(ACT_LOAD, 20, -20, 20, 20);
		queue_item(ACT_QUERY, 15, 0, 25, 0);
		queue_item(ACT_QUERY, 25, 3, -1, -3);
		queue_item(ACT_QUERY, 5, 0, 5, 0);
		queue_item(ACT_LOAD, 32767, -32768, -32768, 32767);
		queue_item(ACT_QUERY, 32767, 32767, -32768, -32768);
		queue_item(ACT_UNKNOWN, 32767, -32768, 32767, -32768);

		n_random = 0;
		seq = 0;
		while (n_random < RANDOM_ITEMS) begin
			wall_x0.delete();
			wall_y0.delete();
			wall_x1.delete();
			wall_y1.delete();
			wide = ($urandom_range(0, 3) == 0);
			if (seq == 0)
				n_walls = MAX_WALLS + 2;
			else if ($urandom_range(0, 9) < 7)
				n_walls = $urandom_range(1, 8);
			else if ($urandom_range(0, 2) < 2)
				n_walls = $urandom_range(9, 30);
			else
				n_walls = $urandom_range(MAX_WALLS - 8, MAX_WALLS + 6);
			if ($urandom_range(0, 7) != 0) begin
				queue_item(ACT_CLEAR, any_coord(), any_coord(), any_coord(),
					any_coord(), seq == 3 || $urandom_range(0, 5) == 0);
				n_random++;
			end
			for (int i = 0; i < n_walls; i++) begin
				if (wide) begin
					wall_x0.insert(wall_x0.size(), any_coord());
					wall_y0.insert(wall_y0.size(), any_coord());
					wall_x1.insert(wall_x1.size(), any_coord());
					wall_y1.insert(wall_y1.size(), any_coord());
				end else begin
					wall_x0.insert(wall_x0.size(), near_coord());
					wall_y0.insert(wall_y0.size(), near_coord());
					wall_x1.insert(wall_x1.size(), near_coord());
					wall_y1.insert(wall_y1.size(), near_coord());
				end
				queue_item(ACT_LOAD, wall_x0[i], wall_y0[i], wall_x1[i], wall_y1[i]);
				n_random++;
			end
			n_queries = $urandom_range(2, 8);
			for (int i = 0; i < n_queries; i++) begin
				kind = $urandom_range(0, 9);
				w = $urandom_range(0, n_walls - 1);
				dx = wall_x1[w] - wall_x0[w];
				dy = wall_y1[w] - wall_y0[w];
				if (wide || kind < 2) begin
					queue_item(ACT_QUERY, any_coord(), any_coord(), any_coord(),
						any_coord());
				end else if (kind < 5) begin
					queue_item(ACT_QUERY, near_coord(), near_coord(), near_coord(),
						near_coord());
				end else if (kind < 8) begin
					mx = (wall_x0[w] + wall_x1[w]) / 2;
					my = (wall_y0[w] + wall_y1[w]) / 2;
					px = -dy;
					py = dx;
					queue_item(ACT_QUERY, mx + px, my + py, mx - px, my - py);
				end else if (kind == 8) begin
					queue_item(ACT_QUERY, wall_x0[w] - dx, wall_y0[w] - dy,
						wall_x1[w] + dx, wall_y1[w] + dy);
				end else begin
					pick = $urandom_range(1, 3);
					queue_item(ACT_QUERY, wall_x0[w] + pick, wall_y0[w],
						wall_x1[w] + pick, wall_y1[w]);
				end
				n_random++;
			end
			if ($urandom_range(0, 9) == 0)
				queue_item(ACT_UNKNOWN, any_coord(), any_coord(), any_coord(),
					any_coord());
			seq++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = ACT_LOAD;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		handed_over = 1'b0;
		items_sent = 0;
		answers_seen = 0;
		hold_left = 0;
		held_once = 1'b0;
		failures = 0;
		model_wall_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_answers.insert(expected_answers.size(),
				apply_to_wall_table(offered_item));
			items_sent++;
			handed_over = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || handed_over)) begin
			handed_over = 1'b0;
			if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_items[0].drain_first && expected_answers.size() != 0) begin
				in_valid <= 1'b0;
			end else if (!(items_sent >= 700 && items_sent < 1000)
					&& $urandom_range(0, 99) < 18) begin
				in_valid <= 1'b0;
			end else begin
				offered_item = pending_items.pop_front();
				action <= offered_item.act;
				start_x <= offered_item.sx;
				start_y <= offered_item.sy;
				end_x <= offered_item.ex;
				end_y <= offered_item.ey;
				in_valid <= 1'b1;
			end
		end
	end

	// The receiver holds off once for a long stretch so that the input stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held_once && answers_seen >= 400) begin
				held_once = 1'b1;
				hold_left = 250;
				out_ready <= 1'b0;
			end else if (!(answers_seen >= 700 && answers_seen < 1000)
					&& $urandom_range(0, 99) < 18) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (expected_answers.size() == 0) begin
				$error("result transfer with no expected answer");
				failures++;
			end else begin
				exp_a = expected_answers.pop_front();
				if (hit !== exp_a.hit) begin
					$error("hit: expected %0b, actual %0b", exp_a.hit, hit);
					failures++;
				end
				if (table_full !== exp_a.full) begin
					$error("table_full: expected %0b, actual %0b", exp_a.full, table_full);
					failures++;
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
